[src/hbd_pkg.sv]
package hbd_pkg;

	localparam int STATE_W = 9;
	localparam int SYM_W = 8;
	localparam int CODE_W = 8;
	localparam int COUNT_W = 4;
	localparam int PACK_W = 64;
	localparam int BITS_PER_ITEM = 8;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef logic [STATE_W-1:0] node_t;

	typedef struct packed {
		node_t              next_zero;
		node_t              next_one;
		logic               leaf;
		logic [SYM_W-1:0]   symbol;
	} entry_t;

	typedef struct packed {
		node_t zero;
		node_t one;
	} root_t;

	typedef struct packed {
		logic   en;
		node_t  node;
		entry_t entry;
	} tbl_wr_t;

	typedef struct packed {
		logic               action;
		node_t              entry_index;
		node_t              next_if_zero;
		node_t              next_if_one;
		logic               entry_is_leaf;
		logic [SYM_W-1:0]   leaf_symbol;
		logic [CODE_W-1:0]  code_bits;
		logic [COUNT_W-1:0] bit_count;
		logic               restart;
	} item_t;

	typedef struct packed {
		node_t              state_after;
		logic [COUNT_W-1:0] symbol_count;
		logic [PACK_W-1:0]  symbols_packed;
	} result_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WALK,
		SEQ_DONE
	} seq_state_t;

	function automatic logic node_in_range(node_t n, int unsigned depth);
		return {{(32-STATE_W){1'b0}}, n} < depth;
	endfunction

endpackage

[src/hbd_table.sv]
module hbd_table #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic             clk,
	input  hbd_pkg::tbl_wr_t wr,
	input  logic             rd_en,
	input  hbd_pkg::node_t   rd_node,
	output hbd_pkg::entry_t  rd_entry,
	output hbd_pkg::root_t   root
);
	import hbd_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;
	root_t  root_q;

	always_ff @(posedge clk) begin
		if (wr.en && node_in_range(wr.node, TABLE_DEPTH)) begin
			mem[AW'(wr.node)] <= wr.entry;
		end
		if (rd_en && node_in_range(rd_node, TABLE_DEPTH)) begin
			rd_q <= mem[AW'(rd_node)];
		end
	end

	// copy of the root's next states, used when stepping out of a leaf
	always_ff @(posedge clk) begin
		if (wr.en && wr.node == '0) begin
			root_q <= '{zero: wr.entry.next_zero, one: wr.entry.next_one};
		end
	end

	assign rd_entry = rd_q;
	assign root = root_q;

endmodule

[src/hbd_seq.sv]
module hbd_seq #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hbd_pkg::item_t       item,
	input  logic                 take,
	output hbd_pkg::seq_status_t status,
	output hbd_pkg::result_t     result,
	output hbd_pkg::tbl_wr_t     wr,
	output logic                 rd_en,
	output hbd_pkg::node_t       rd_node,
	input  hbd_pkg::entry_t      rd_entry,
	input  hbd_pkg::root_t       root
);
	import hbd_pkg::*;

	seq_state_t         state_q, state_d;
	node_t              st_q;
	node_t              cur_q;
	logic [CODE_W-1:0]  bits_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] found_q;
	logic [PACK_W-1:0]  packed_q;
	logic               pend_q;

	logic [COUNT_W-1:0] clamp;
	node_t              start_node;
	logic               st_valid;
	node_t              src_zero, src_one;
	node_t              step_node;
	logic               hit;
	logic               is_decode;

	assign is_decode = (item.action == ACT_DECODE);
	assign clamp = (item.bit_count > COUNT_W'(BITS_PER_ITEM)) ?
		COUNT_W'(BITS_PER_ITEM) : item.bit_count;
	assign start_node = item.restart ? '0 : cur_q;
	assign st_valid = node_in_range(st_q, TABLE_DEPTH);
	// a leaf continues from the root
	assign src_zero = rd_entry.leaf ? root.zero : rd_entry.next_zero;
	assign src_one = rd_entry.leaf ? root.one : rd_entry.next_one;
	assign step_node = !st_valid ? '0 : (bits_q[0] ? src_one : src_zero);
	assign hit = pend_q && st_valid && rd_entry.leaf;

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_node = step_node;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					if (is_decode) begin
						rd_en = 1'b1;
						rd_node = start_node;
						state_d = SEQ_WALK;
					end else begin
						state_d = SEQ_DONE;
					end
				end
			end
			SEQ_WALK: begin
				if (count_q != '0) begin
					rd_en = 1'b1;
				end else begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_DONE: begin
				if (take) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			cur_q <= '0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= (state_q == SEQ_WALK) && (count_q != '0);
			if (state_q == SEQ_DONE && take) begin
				cur_q <= st_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					st_q <= is_decode ? start_node : cur_q;
					bits_q <= item.code_bits;
					count_q <= is_decode ? clamp : '0;
					found_q <= '0;
					packed_q <= '0;
				end
			end
			SEQ_WALK: begin
				// settle the leaf check of the step taken last cycle
				if (hit) begin
					packed_q[{found_q[2:0], 3'b000} +: SYM_W] <= rd_entry.symbol;
					found_q <= found_q + 1'b1;
				end
				if (count_q != '0) begin
					st_q <= step_node;
					bits_q <= bits_q >> 1;
					count_q <= count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr.en = start && (state_q == SEQ_IDLE) && (item.action == ACT_LOAD);
	assign wr.node = item.entry_index;
	assign wr.entry = '{
		next_zero: item.next_if_zero,
		next_one:  item.next_if_one,
		leaf:      item.entry_is_leaf,
		symbol:    item.leaf_symbol
	};

	assign status.idle = (state_q == SEQ_IDLE);
	assign status.done = (state_q == SEQ_DONE);

	assign result.state_after = st_q;
	assign result.symbol_count = found_q;
	assign result.symbols_packed = packed_q;

`ifndef SYNTHESIS
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_DONE && !take) |=>
		(state_q == SEQ_DONE && $stable(st_q) && $stable(found_q)))
		else $error("finished result changed while waiting");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == SEQ_IDLE && item.action == ACT_LOAD) |=>
		(state_q == SEQ_DONE && found_q == '0))
		else $error("load produced symbols");

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_WALK) |->
		(({1'b0, found_q} + {1'b0, count_q}) <= (COUNT_W + 1)'(BITS_PER_ITEM)))
		else $error("more symbols than bits");

	a_state_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_DONE && take) |=> (cur_q == $past(st_q)))
		else $error("decoder state not committed");
`endif

endmodule

[src/table_driven_huffman_bit_decoder.sv]
// a load item writes one table entry and gives a result with no symbols; a decode item
// walks the table one code bit at a time (bit_count capped at 8)
// one item at a time: the input stalls until the result is passed on; each
// code bit is one dependent read of the state table memory
// reset: arst_n clears the sequencer, output valid and the state to the root;
// table contents are undefined until loaded
module table_driven_huffman_bit_decoder #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [hbd_pkg::STATE_W-1:0]   entry_index,
	input  logic [hbd_pkg::STATE_W-1:0]   next_if_zero,
	input  logic [hbd_pkg::STATE_W-1:0]   next_if_one,
	input  logic                          entry_is_leaf,
	input  logic [hbd_pkg::SYM_W-1:0]     leaf_symbol,
	input  logic [hbd_pkg::CODE_W-1:0]    code_bits,
	input  logic [hbd_pkg::COUNT_W-1:0]   bit_count,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hbd_pkg::STATE_W-1:0]   state_after,
	output logic [hbd_pkg::COUNT_W-1:0]   symbol_count,
	output logic [hbd_pkg::PACK_W-1:0]    symbols_packed
);
	import hbd_pkg::*;

	item_t       item;
	seq_status_t status;
	result_t     result;
	tbl_wr_t     wr;
	logic        rd_en;
	node_t       rd_node;
	entry_t      rd_entry;
	root_t       root;
	logic        start;
	logic        take;
	logic        out_valid_q;
	result_t     out_q;

	assign item = '{
		action:        action,
		entry_index:   entry_index,
		next_if_zero:  next_if_zero,
		next_if_one:   next_if_one,
		entry_is_leaf: entry_is_leaf,
		leaf_symbol:   leaf_symbol,
		code_bits:     code_bits,
		bit_count:     bit_count,
		restart:       restart
	};

	assign in_stall = !status.idle;
	assign start = in_valid && status.idle;
	// result moves into the output register when that is empty or draining
	assign take = status.done && (!out_valid_q || !out_stall);

	hbd_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_node  (rd_node),
		.rd_entry (rd_entry),
		.root     (root)
	);

	hbd_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.take     (take),
		.status   (status),
		.result   (result),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_node  (rd_node),
		.rd_entry (rd_entry),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign state_after = out_q.state_after;
	assign symbol_count = out_q.symbol_count;
	assign symbols_packed = out_q.symbols_packed;

endmodule
